@@ design/rdp_pkg.sv @@
// Shared types, constants and alphabet helpers for the radix digit printer.
package rdp_pkg;

  localparam int MAX_BASE   = 16;
  localparam int MAX_DIGITS = 32;

  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 4;
  localparam int RADIX_W = 5;
  localparam int COUNT_W = 6;
  localparam int PTR_W   = 5;
  localparam int STEP_W  = 5;
  localparam int ALPHA_W = 64;
  localparam int CFG_A_W = 2;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_BASE_SIZE     = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_ALPHABET_LOW  = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_ALPHABET_HIGH = 2'd2;

  localparam logic [RADIX_W-1:0] BASE_SIZE_RST     = 5'd10;
  localparam logic [ALPHA_W-1:0] ALPHABET_LOW_RST  = 64'h3736353433323130;
  localparam logic [ALPHA_W-1:0] ALPHABET_HIGH_RST = 64'h0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TEST,
    ST_DIV,
    ST_READ,
    ST_LOAD,
    ST_SEND
  } state_t;

  // character of one digit: digits 0..7 in the low word, 8..15 in the high word
  function automatic logic [CHAR_W-1:0] glyph(input logic [ALPHA_W-1:0] lo,
                                              input logic [ALPHA_W-1:0] hi,
                                              input logic [DIGIT_W-1:0] d);
    logic [ALPHA_W-1:0] word;
    word = d[3] ? hi : lo;
    word = word >> {d[2:0], 3'b000};
    return word[CHAR_W-1:0];
  endfunction

  // radix in use: base size saturated to 2..16, cut at the first NUL character
  function automatic logic [RADIX_W-1:0] radix_of(input logic [RADIX_W-1:0] size,
                                                  input logic [ALPHA_W-1:0] lo,
                                                  input logic [ALPHA_W-1:0] hi);
    logic [RADIX_W-1:0] n;
    logic [RADIX_W-1:0] r;
    n = size;
    if (n < RADIX_W'(2)) n = RADIX_W'(2);
    if (n > RADIX_W'(MAX_BASE)) n = RADIX_W'(MAX_BASE);
    r = n;
    // descending scan so the lowest NUL position wins
    for (int k = MAX_BASE - 1; k >= 0; k--) begin
      if ((RADIX_W'(k) < n) && (glyph(lo, hi, DIGIT_W'(k)) == '0)) r = RADIX_W'(k);
    end
    return r;
  endfunction

endpackage

@@ design/radix_digit_printer.sv @@
// Top level: unsigned 32-bit value to a character string in a configured base.
// Each transaction on the in_ side carries one 32-bit value; the block answers with
// one out_ transaction per digit, most significant first, out_tlast on the final
// one, or with none when the alphabet in use is shorter than two characters or
// repeats a character. One value is converted at a time and in_tready stays low
// until its last character has been taken. Each value is worked through by a
// single shared restoring divider that retires one quotient bit per cycle: the
// alphabet check walks the rows of the radix in use, each digit but the most
// significant takes one test plus 32 divide steps, the final digit a single test,
// and each character a stack read, a load of the output register and a send that
// waits for out_tready. Digits are held in a 32-entry stack memory with a
// registered read port.
module radix_digit_printer (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [rdp_pkg::CFG_A_W-1:0]   cfg_addr,
  input  logic [rdp_pkg::ALPHA_W-1:0]   cfg_wdata,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rdp_pkg::VALUE_W-1:0]   in_tdata,   // [31:0] value
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rdp_pkg::CHAR_W-1:0]    out_tdata,  // [7:0] character
  output logic                          out_tlast   // last_digit
);
  import rdp_pkg::*;

  // configuration registers
  logic [RADIX_W-1:0] base_size_r;
  logic [ALPHA_W-1:0] alpha_lo_r;
  logic [ALPHA_W-1:0] alpha_hi_r;

  // sequencer state
  state_t             state_r, state_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;      // remaining value, also the dividend shifter
  logic [DIGIT_W-1:0] rem_r, rem_nxt;      // partial remainder
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [RADIX_W-1:0] radix_r, radix_nxt;
  logic [DIGIT_W-1:0] row_r, row_nxt;      // alphabet row under check
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  // digit stack memory
  logic [DIGIT_W-1:0] stack_mem [MAX_DIGITS];
  logic               mem_we;
  logic [PTR_W-1:0]   mem_waddr;
  logic [DIGIT_W-1:0] mem_wdata;
  logic [DIGIT_W-1:0] rd_data_r;

  // shared divide step and helpers
  logic [RADIX_W-1:0] trial;
  logic               trial_ge;
  logic [DIGIT_W-1:0] trial_diff;
  logic [DIGIT_W-1:0] step_rem;
  logic [VALUE_W-1:0] step_quot;
  logic [RADIX_W-1:0] radix_calc;
  logic               row_dup;
  logic               row_done;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  assign radix_calc = radix_of(base_size_r, alpha_lo_r, alpha_hi_r);

  // one restoring division step: shift in the next dividend bit, subtract if it fits
  assign trial      = {rem_r, val_r[VALUE_W-1]};
  assign trial_ge   = (trial >= radix_r);
  assign trial_diff = DIGIT_W'(trial - radix_r);
  assign step_rem   = trial_ge ? trial_diff : trial[DIGIT_W-1:0];
  assign step_quot  = {val_r[VALUE_W-2:0], trial_ge};

  // one alphabet row: does character row_r repeat later within the radix
  always_comb begin
    row_dup = 1'b0;
    for (int b = 0; b < MAX_BASE; b++) begin
      if ((DIGIT_W'(b) > row_r) && (RADIX_W'(b) < radix_r) &&
          (glyph(alpha_lo_r, alpha_hi_r, DIGIT_W'(b)) ==
           glyph(alpha_lo_r, alpha_hi_r, row_r))) begin
        row_dup = 1'b1;
      end
    end
  end
  assign row_done = ({1'b0, row_r} == (radix_r - RADIX_W'(2)));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_size_r <= BASE_SIZE_RST;
      alpha_lo_r  <= ALPHABET_LOW_RST;
      alpha_hi_r  <= ALPHABET_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_BASE_SIZE:     base_size_r <= cfg_wdata[RADIX_W-1:0];
        CFG_ALPHABET_LOW:  alpha_lo_r  <= cfg_wdata;
        CFG_ALPHABET_HIGH: alpha_hi_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      val_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      val_r       <= val_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    radix_r    <= radix_nxt;
    row_r      <= row_nxt;
    ptr_r      <= ptr_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // digit stack: one write port, registered read port
  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= stack_mem[ptr_r];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    radix_nxt     = radix_r;
    row_nxt       = row_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r[PTR_W-1:0];
    mem_wdata     = val_r[DIGIT_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          val_nxt   = in_tdata;
          cnt_nxt   = '0;
          radix_nxt = radix_calc;
          row_nxt   = '0;
          // an alphabet shorter than two characters yields no output
          if (radix_calc >= RADIX_W'(2)) state_nxt = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (row_dup) state_nxt = ST_IDLE;
        else if (row_done) state_nxt = ST_TEST;
        else row_nxt = row_r + DIGIT_W'(1);
      end

      ST_TEST: begin
        if ((val_r >= VALUE_W'(radix_r)) && (cnt_r < COUNT_W'(MAX_DIGITS - 1))) begin
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end else begin
          // most significant digit: push it and start emitting
          mem_we    = 1'b1;
          mem_wdata = val_r[DIGIT_W-1:0];
          cnt_nxt   = cnt_r + COUNT_W'(1);
          ptr_nxt   = cnt_r[PTR_W-1:0];
          state_nxt = ST_READ;
        end
      end

      ST_DIV: begin
        rem_nxt  = step_rem;
        val_nxt  = step_quot;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(VALUE_W - 1)) begin
          mem_we    = 1'b1;
          mem_wdata = step_rem;
          cnt_nxt   = cnt_r + COUNT_W'(1);
          state_nxt = ST_TEST;
        end
      end

      ST_READ: begin
        state_nxt = ST_LOAD;
      end

      ST_LOAD: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = glyph(alpha_lo_r, alpha_hi_r, rd_data_r);
        out_last_nxt  = (ptr_r == '0);
        state_nxt     = ST_SEND;
      end

      ST_SEND: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            ptr_nxt   = ptr_r - PTR_W'(1);
            state_nxt = ST_READ;
          end
        end
      end

      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

endmodule

@@ design/rdp_checker.sv @@
// Port-level checker for the radix digit printer, bound to the top level.
module rdp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [rdp_pkg::CHAR_W-1:0]    out_tdata,
  input logic                          out_tlast
);

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("rdp: stalled output changed");

  // one value at a time: never ready while a character is pending
  a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("rdp: input ready while output valid");

  // each character is followed by a gap for the next stack read
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid)
    else $error("rdp: back-to-back characters");

  // no character right after a value is taken
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("rdp: output right after input");

endmodule

bind radix_digit_printer rdp_checker u_rdp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ sim/testbench.sv @@
// Self-checking testbench for radix_digit_printer: predicts the digit characters of each value.
module testbench;
  import rdp_pkg::*;

  localparam int SETTLE_CYCLES   = 64;     // idle margin before a register write
  localparam int HOLD_CYCLES     = 400;    // long receiver hold-off
  localparam int WATCHDOG_LIMIT  = 10000;  // cycles without any transaction
  localparam int RANDOM_SPELLED  = 260;    // random values that must produce characters
  localparam logic [CFG_A_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_char_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_A_W-1:0]   cfg_addr   = '0;
  logic [ALPHA_W-1:0]   cfg_wdata  = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [VALUE_W-1:0]   in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [CHAR_W-1:0]    out_tdata;
  logic                 out_tlast;

  // shadow of the configuration registers
  logic [RADIX_W-1:0]   size_reg  = BASE_SIZE_RST;
  logic [ALPHA_W-1:0]   alpha_lo  = ALPHABET_LOW_RST;
  logic [ALPHA_W-1:0]   alpha_hi  = ALPHABET_HIGH_RST;

  logic [VALUE_W-1:0]   values_to_send[$];
  digit_char_t          pending_chars[$];

  logic                 in_hs = 1'b0;
  bit                   calm = 1'b0;
  int unsigned          hold_asked = 0;
  int unsigned          hold_served = 0;
  int unsigned          mismatch_count = 0;
  int unsigned          values_spelled = 0;
  int unsigned          silent_values = 0;
  int unsigned          chars_checked = 0;
  int unsigned          cfg_writes = 0;
  int unsigned          longest = 0;
  int unsigned          quiet_cycles = 0;

  radix_digit_printer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // mostly short gaps, a few long ones, none in calm phases
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned kind;
    kind = $urandom_range(0, 19);
    if (kind < 8) return $urandom;
    if (kind < 13) return $urandom_range(0, 300);
    if (kind < 17) return $urandom >> $urandom_range(1, 31);
    if (kind < 19) return (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
    return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
  endfunction

  // alphabet character of one digit under the shadow registers
  function automatic logic [CHAR_W-1:0] char_of(input int unsigned d);
    logic [ALPHA_W-1:0] word;
    word = (d >= 8) ? alpha_hi : alpha_lo;
    return word[(d % 8) * 8 +: 8];
  endfunction

  // predict the characters of one accepted value
  task automatic spell_value(input logic [VALUE_W-1:0] value);
    int unsigned  n;
    int unsigned  radix;
    int unsigned  count;
    logic [31:0]  rest;
    logic [3:0]   stack[MAX_DIGITS];
    bit           cut;
    bit           repeated;
    n = size_reg;
    if (n < 2) n = 2;
    if (n > MAX_BASE) n = MAX_BASE;
    // a NUL character ends the alphabet early
    radix = n;
    cut = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (!cut && char_of(k) == 8'h00) begin
        radix = k;
        cut = 1'b1;
      end
    end
    repeated = 1'b0;
    for (int a = 0; a < radix; a++)
      for (int b = a + 1; b < radix; b++)
        if (char_of(a) == char_of(b)) repeated = 1'b1;
    if (radix < 2 || repeated) begin
      silent_values++;
      return;
    end
    // remainders, least significant first
    count = 0;
    rest = value;
    while (rest >= radix && count < MAX_DIGITS - 1) begin
      stack[count] = DIGIT_W'(rest % radix);
      rest = rest / radix;
      count++;
    end
    stack[count] = rest[3:0];
    count++;
    for (int k = 0; k < count; k++)
      pending_chars.push_back('{ch: char_of(stack[count - 1 - k]), last: (k == count - 1)});
    values_spelled++;
    if (count > longest) longest = count;
  endtask

  // input driver: one value per transaction, random gaps between
  always @(negedge clk) begin
    int unsigned gap_left;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else if (!(in_tvalid && !in_hs)) begin
      if (gap_left > 0) begin
        in_tvalid <= 1'b0;
        gap_left--;
      end else if (values_to_send.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= values_to_send.pop_front();
        gap_left  = pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    int unsigned hold_left;
    int unsigned stall_left;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  = 0;
      stall_left = 0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_served != hold_asked) begin
      out_tready <= 1'b0;
      hold_served++;
      hold_left = HOLD_CYCLES;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    digit_char_t want;
    if (!rst_n) begin
      in_hs <= 1'b0;
    end else begin
      in_hs <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) spell_value(in_tdata);
      if (out_tvalid && out_tready) begin
        chars_checked++;
        if (pending_chars.size() == 0) begin
          flag_mismatch($sformatf("character 0x%02h with nothing pending", out_tdata));
        end else begin
          want = pending_chars.pop_front();
          if (out_tdata !== want.ch)
            flag_mismatch($sformatf("character 0x%02h, expected 0x%02h", out_tdata, want.ch));
          if (out_tlast !== want.last)
            flag_mismatch($sformatf("tlast %b, expected %b", out_tlast, want.last));
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles at %0t", WATCHDOG_LIMIT, $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CFG_A_W-1:0] addr, input logic [ALPHA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (addr)
      CFG_BASE_SIZE:     size_reg = data[RADIX_W-1:0];
      CFG_ALPHABET_LOW:  alpha_lo = data;
      CFG_ALPHABET_HIGH: alpha_hi = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_alphabet(input logic [RADIX_W-1:0] size, input logic [ALPHA_W-1:0] lo,
                              input logic [ALPHA_W-1:0] hi);
    logic [ALPHA_W-1:0] word;
    word = {$urandom, $urandom};
    word[RADIX_W-1:0] = size;
    cfg_write(CFG_BASE_SIZE, word);
    cfg_write(CFG_ALPHABET_LOW, lo);
    cfg_write(CFG_ALPHABET_HIGH, hi);
    @(posedge clk);
  endtask

  // wait until every value is accepted and every character has come back
  task automatic wait_idle();
    do @(posedge clk);
    while (values_to_send.size() != 0 || in_tvalid || pending_chars.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [CHAR_W-1:0]  glyphs[MAX_BASE];
    logic [255:0]       taken;
    logic [ALPHA_W-1:0] lo;
    logic [ALPHA_W-1:0] hi;
    logic [CHAR_W-1:0]  c;
    int unsigned        a;
    int unsigned        b;
    int unsigned        round;
    int unsigned        goal;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: digits 8 and 9 are NUL, so octal
    values_to_send.push_back(32'd0);
    values_to_send.push_back(32'd7);
    values_to_send.push_back(32'd8);
    values_to_send.push_back(32'hFFFF_FFFF);
    wait_idle();

    // binary, longest strings
    set_alphabet(5'd2, ALPHABET_LOW_RST, 64'h0);
    values_to_send.push_back(32'd1);
    values_to_send.push_back(32'hFFFF_FFFF);
    values_to_send.push_back(32'h8000_0000);
    wait_idle();

    // hexadecimal
    set_alphabet(5'd16, ALPHABET_LOW_RST, 64'h4645_4443_4241_3938);
    values_to_send.push_back(32'd0);
    values_to_send.push_back(32'h0000_000F);
    values_to_send.push_back(32'h0000_0010);
    values_to_send.push_back(32'hFFFF_FFFF);
    values_to_send.push_back(32'h1234_5678);
    wait_idle();

    // size below two saturates to binary, above sixteen to hexadecimal
    set_alphabet(5'd0, ALPHABET_LOW_RST, 64'h4645_4443_4241_3938);
    values_to_send.push_back(32'd5);
    wait_idle();
    set_alphabet(5'd31, ALPHABET_LOW_RST, 64'h4645_4443_4241_3938);
    values_to_send.push_back(32'hDEAD_BEEF);
    wait_idle();
    set_alphabet(5'd1, ALPHABET_LOW_RST, 64'h4645_4443_4241_3938);
    values_to_send.push_back(32'd6);
    wait_idle();

    // repeated character in use: no output
    set_alphabet(5'd16, ALPHABET_LOW_RST, 64'h3045_4443_4241_3938);
    values_to_send.push_back(32'h0000_1234);
    values_to_send.push_back(32'd0);
    wait_idle();

    // NUL at digit one, then at digit zero: radix under two, no output
    set_alphabet(5'd10, 64'h3736_3534_3332_0030, 64'h3938);
    values_to_send.push_back(32'd3);
    wait_idle();
    set_alphabet(5'd10, 64'h3736_3534_3332_3100, 64'h3938);
    values_to_send.push_back(32'd9);
    wait_idle();

    // all-ones alphabet repeats everywhere
    set_alphabet(5'd8, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    values_to_send.push_back(32'd77);
    wait_idle();

    // decimal; repeats beyond the size in use do not matter, unused index ignored
    set_alphabet(5'd10, ALPHABET_LOW_RST, 64'h3030_3030_3030_3938);
    cfg_write(CFG_UNUSED, {$urandom, $urandom});
    @(posedge clk);
    values_to_send.push_back(32'd0);
    values_to_send.push_back(32'd9);
    values_to_send.push_back(32'd10);
    values_to_send.push_back(32'hFFFF_FFFF);
    wait_idle();

    // random settings and values
    goal = values_spelled + RANDOM_SPELLED;
    round = 0;
    while (values_spelled < goal) begin
      // sixteen distinct nonzero characters, sometimes spoiled
      taken = '0;
      for (int i = 0; i < MAX_BASE; i++) begin
        do c = CHAR_W'($urandom_range(1, 255));
        while (taken[c]);
        taken[c] = 1'b1;
        glyphs[i] = c;
      end
      case ($urandom_range(0, 9))
        0: glyphs[$urandom_range(0, MAX_BASE - 1)] = 8'h00;
        1: begin
          a = $urandom_range(0, MAX_BASE - 1);
          b = (a + $urandom_range(1, MAX_BASE - 1)) % MAX_BASE;
          glyphs[b] = glyphs[a];
        end
        default: ;
      endcase
      for (int i = 0; i < 8; i++) begin
        lo[i*8 +: 8] = glyphs[i];
        hi[i*8 +: 8] = glyphs[i + 8];
      end
      if ($urandom_range(0, 3) == 0) set_alphabet(RADIX_W'($urandom_range(0, 31)), lo, hi);
      else set_alphabet(RADIX_W'($urandom_range(2, 16)), lo, hi);

      calm = (round % 4 == 3);
      if (round % 5 == 0) hold_asked++;
      repeat ($urandom_range(15, 35)) values_to_send.push_back(pick_value());
      wait_idle();
      round++;
    end

    if (pending_chars.size() != 0)
      flag_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
    $display("Run: %0d values printed as %0d characters, %0d values with an unusable alphabet",
             values_spelled, chars_checked, silent_values);
    $display("Run: %0d register writes, longest string %0d characters, %0d mismatches",
             cfg_writes, longest, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
